### sv/multi_queue_shared_buffer_top_defines.svh
// assertion macros for the shared-buffer queue block
`ifndef MULTI_QUEUE_SHARED_BUFFER_TOP_DEFINES_SVH
`define MULTI_QUEUE_SHARED_BUFFER_TOP_DEFINES_SVH

// same-cycle implication, checked on the rising clock, off during reset
`define MQSB_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

// implication checked a fixed number of cycles later
`define MQSB_ASSERT_LATER(lbl, pre, dly, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> ##dly (post)) \
      else $error(msg);

`endif

### sv/mqsb_pkg.sv
// shared types and constants of the shared-buffer queue block
package mqsb_pkg;

   // sizing
   localparam int CAPACITY   = 16;
   localparam int QUEUES     = 4;
   localparam int DATA_WIDTH = 32;

   // fixed port field widths
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;
   localparam int QIDX_W     = 2;
   localparam int STATUS_W   = 2;

   // derived widths
   localparam int SLOT_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LINK_W  = $clog2(CAPACITY + 1);
   localparam int QUEUE_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;
   localparam int STORE_W = (DATA_WIDTH < REQ_DATA_W) ? DATA_WIDTH : REQ_DATA_W;

   // a link equal to the capacity marks the end of a chain
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef logic [LINK_W-1:0] link_type;

endpackage

### sv/multi_queue_shared_buffer_top.sv
// Several FIFO queues sharing one slot store, chained through a link store and a free list.
// Items are accepted in every cycle (busy is always low); each item gives one result, strobed
// on rsp_valid after the request and result registers. The request is registered, then one pass
// of logic reads the queue pointers and the one link entry it needs and updates them before
// the next item arrives, so back-to-back items on the same queue need no forwarding. The
// receiver cannot stall: a result is present for exactly one cycle. Push reports full when
// no slot is free, pop reports empty (with zero data) when the queue has nothing.
`include "multi_queue_shared_buffer_top_defines.svh"

module multi_queue_shared_buffer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_operation,
   input  logic [mqsb_pkg::QIDX_W-1:0]         req_queue_index,
   input  logic signed [mqsb_pkg::REQ_DATA_W-1:0] req_data_in,
   output logic                                rsp_valid,
   output logic signed [mqsb_pkg::RSP_DATA_W-1:0] rsp_data_out,
   output logic [mqsb_pkg::STATUS_W-1:0]       rsp_status
);
   import mqsb_pkg::*;

   // request register
   logic                  in_vld_ff;
   logic                  in_op_ff;
   logic [QIDX_W-1:0]     in_q_ff;
   logic [STORE_W-1:0]    in_data_ff;

   // queue state
   link_type              head_ff [QUEUES];
   link_type              head_in [QUEUES];
   link_type              tail_ff [QUEUES];
   link_type              tail_in [QUEUES];
   link_type              free_head_ff;
   link_type              free_head_in;
   link_type              link_ff [CAPACITY];
   logic [CAPACITY-1:0]   link_vld_ff;
   logic [STORE_W-1:0]    value_ff [CAPACITY];

   // result register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;
   status_type            rsp_status_ff;
   status_type            rsp_status_in;

   // update strobes
   logic                  link_we;
   logic [SLOT_W-1:0]     link_wa;
   link_type              link_wd;
   logic                  value_we;
   logic [SLOT_W-1:0]     value_wa;

   // working signals
   logic [QUEUE_W-1:0]    q;
   link_type              head;
   link_type              tail;
   link_type              rd_addr;
   logic [SLOT_W-1:0]     rd_idx;
   link_type              link_rd;
   logic                  free_ok;
   logic                  head_ok;

   assign busy = 1'b0;

   // capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= start;
      end
      if (start) begin
         in_op_ff   <= req_operation;
         in_q_ff    <= req_queue_index;
         in_data_ff <= req_data_in[STORE_W-1:0];
      end
   end

   // pointer lookup and one-pass queue update
   always_comb begin
      q       = QUEUE_W'(in_q_ff % QUEUES);
      head    = head_ff[q];
      tail    = tail_ff[q];
      free_ok = (free_head_ff < NULL_LINK);
      head_ok = (head < NULL_LINK);
      rd_addr = (in_op_ff == OP_POP) ? head : free_head_ff;
      rd_idx  = rd_addr[SLOT_W-1:0];
      // unwritten links still follow the reset chain
      link_rd = link_vld_ff[rd_idx] ? link_ff[rd_idx] : (LINK_W'(rd_idx) + LINK_W'(1));

      head_in       = head_ff;
      tail_in       = tail_ff;
      free_head_in  = free_head_ff;
      link_we       = 1'b0;
      link_wa       = tail[SLOT_W-1:0];
      link_wd       = free_head_ff;
      value_we      = 1'b0;
      value_wa      = free_head_ff[SLOT_W-1:0];
      rsp_data_in   = '0;
      rsp_status_in = ST_OK;

      if (in_vld_ff) begin
         if (in_op_ff == OP_PUSH) begin
            if (!free_ok) begin
               rsp_status_in = ST_FULL;
            end else begin
               free_head_in = link_rd;
               if (!head_ok) begin
                  head_in[q] = free_head_ff;
               end else begin
                  // append after the current tail
                  link_we = 1'b1;
                  link_wa = tail[SLOT_W-1:0];
                  link_wd = free_head_ff;
               end
               tail_in[q] = free_head_ff;
               value_we   = 1'b1;
            end
         end else begin
            if (!head_ok) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               // the tail's link is stale, so the last item ends the chain by compare
               head_in[q]   = (head == tail) ? NULL_LINK : link_rd;
               link_we      = 1'b1;
               link_wa      = head[SLOT_W-1:0];
               link_wd      = free_head_ff;
               free_head_in = head;
               rsp_data_in  = RSP_DATA_W'(value_ff[head[SLOT_W-1:0]]);
            end
         end
      end
   end

   // pointer and link registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '{default: NULL_LINK};
         tail_ff      <= '{default: NULL_LINK};
         free_head_ff <= '0;
         link_vld_ff  <= '0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_head_ff <= free_head_in;
         if (link_we) begin
            link_vld_ff[link_wa] <= 1'b1;
         end
      end
      if (link_we) begin
         link_ff[link_wa] <= link_wd;
      end
   end

   // slot values
   always_ff @(posedge clock) begin
      if (value_we) begin
         value_ff[value_wa] <= in_data_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= in_vld_ff;
      end
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_status   = rsp_status_ff;

   // checks
   `MQSB_ASSERT_LATER(a_one_result_per_item, start, 2, rsp_valid,
      "accepted item gave no result")
   `MQSB_ASSERT_NOW(a_fail_data_zero, rsp_valid && (rsp_status != ST_OK), rsp_data_out == '0,
      "failed request returned data")
   `MQSB_ASSERT_NOW(a_full_means_no_free, rsp_valid && (rsp_status == ST_FULL),
      free_head_ff == NULL_LINK, "full reported while a slot is free")

endmodule

### tb/sv/multi_queue_shared_buffer_top_tb.sv
// self-checking bench for the shared-buffer multi-queue block: bursty push/pop items, checked results
module multi_queue_shared_buffer_top_tb;
   import mqsb_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 1000;
   localparam int SETTLE_CYCLES = 8;

   // one queued request for the driver
   typedef struct {
      op_type                 op;
      logic [QIDX_W-1:0]      queue;
      logic [REQ_DATA_W-1:0]  data;
      bit                     wait_drain;
   } queue_req_type;

   // one predicted response
   typedef struct {
      logic [RSP_DATA_W-1:0]  data_out;
      status_type             status;
   } queue_rsp_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic                          req_operation = 1'b0;
   logic [QIDX_W-1:0]             req_queue_index = '0;
   logic signed [REQ_DATA_W-1:0]  req_data_in = '0;
   logic                          rsp_valid;
   logic signed [RSP_DATA_W-1:0]  rsp_data_out;
   logic [STATUS_W-1:0]           rsp_status;

   queue_req_type  pending_items[$];
   queue_rsp_type  expected_rsps[$];
   int          error_count = 0;
   int          items_taken = 0;
   int          rsps_seen = 0;
   int          cycle_count = 0;
   int          burst_left = 0;
   int          gap_left = 0;

   // mirror of the shared store, link chain and queue pointers
   logic [STORE_W-1:0]  slot_value[CAPACITY];
   link_type            slot_link[CAPACITY];
   link_type            q_head[QUEUES];
   link_type            q_tail[QUEUES];
   link_type            free_slot;

   multi_queue_shared_buffer_top dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_queue_index (req_queue_index),
      .req_data_in     (req_data_in),
      .rsp_valid       (rsp_valid),
      .rsp_data_out    (rsp_data_out),
      .rsp_status      (rsp_status)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // free list chains every slot in order, all queues empty
   function automatic void clear_buffer_model();
      for (int i = 0; i < CAPACITY; i++) begin
         slot_value[i] = '0;
         slot_link[i] = link_type'(i + 1);
      end
      slot_link[CAPACITY-1] = NULL_LINK;
      for (int i = 0; i < QUEUES; i++) begin
         q_head[i] = NULL_LINK;
         q_tail[i] = NULL_LINK;
      end
      free_slot = '0;
   endfunction

   // apply one push or pop to the mirror and give the response it must produce
   function automatic queue_rsp_type apply_queue_op(input op_type op,
                                                    input logic [QIDX_W-1:0] qidx,
                                                    input logic [REQ_DATA_W-1:0] data);
      queue_rsp_type  rsp;
      int          q;
      link_type    slot;
      rsp.data_out = '0;
      rsp.status = ST_OK;
      q = int'(qidx) % QUEUES;
      if (op == OP_PUSH) begin
         if (free_slot >= CAPACITY) begin
            rsp.status = ST_FULL;
         end else begin
            slot = free_slot;
            free_slot = slot_link[slot];
            // an empty queue is judged by its head; a stale tail is left alone
            if (q_head[q] >= CAPACITY) begin
               q_head[q] = slot;
            end else if (q_tail[q] < CAPACITY) begin
               slot_link[q_tail[q]] = slot;
            end
            slot_link[slot] = NULL_LINK;
            q_tail[q] = slot;
            slot_value[slot] = data[STORE_W-1:0];
         end
      end else begin
         if (q_head[q] >= CAPACITY) begin
            rsp.status = ST_EMPTY;
         end else begin
            slot = q_head[q];
            q_head[q] = slot_link[slot];
            slot_link[slot] = free_slot;
            free_slot = slot;
            rsp.data_out = RSP_DATA_W'(slot_value[slot]);
         end
      end
      return rsp;
   endfunction

   function automatic void add_item(input op_type op, input int q, input logic [REQ_DATA_W-1:0] data,
                                    input bit wait_drain);
      queue_req_type item;
      item.op = op;
      item.queue = QIDX_W'(q);
      item.data = data;
      item.wait_drain = wait_drain;
      pending_items.push_back(item);
   endfunction

   // random values half of the time, else the sign-only, max-positive, all-ones or zero corner
   function automatic logic [REQ_DATA_W-1:0] pick_data();
      case ($urandom_range(0, 7))
         0: return {1'b1, {(REQ_DATA_W-1){1'b0}}};
         1: return {1'b0, {(REQ_DATA_W-1){1'b1}}};
         2: return '1;
         3: return '0;
         default: return REQ_DATA_W'($urandom);
      endcase
   endfunction

   // driver: bursts of items with random gaps, holding off on a drain marker
   always @(posedge clock) begin
      queue_req_type  item;
      bit          next_start;
      if (reset) begin
         start <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else if (!(start && busy)) begin
         if (start) begin
            items_taken++;
         end
         next_start = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_items.size() > 0 &&
                      !(pending_items[0].wait_drain && items_taken != rsps_seen)) begin
            item = pending_items.pop_front();
            req_operation <= item.op;
            req_queue_index <= item.queue;
            req_data_in <= item.data;
            next_start = 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                       : $urandom_range(0, 12);
               gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            end
         end
         start <= next_start;
      end
   end

   // monitor: predict on every accepted item, check every strobed result
   always @(posedge clock) begin
      queue_rsp_type want;
      if (reset) begin
         clear_buffer_model();
      end else begin
         if (start && !busy) begin
            expected_rsps.push_back(apply_queue_op(op_type'(req_operation), req_queue_index,
                                                   req_data_in));
         end
         if (rsp_valid) begin
            rsps_seen <= rsps_seen + 1;
            if (expected_rsps.size() == 0) begin
               report_mismatch("result strobed with no item outstanding");
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data_out !== want.data_out) begin
                  report_mismatch($sformatf("data_out %h, expected %h", rsp_data_out,
                                            want.data_out));
               end
               if (rsp_status !== want.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d (%s)", rsp_status,
                                            want.status, want.status.name()));
               end
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int  mode;
      int  len;
      int  focus_q;
      bit  focused;
      bit  drain;
      int  count;
      op_type op;

      // directed: empty pop, fill the store (corner values first), push on full
      add_item(OP_POP, 3, pick_data(), 1'b0);
      add_item(OP_PUSH, 0, {1'b1, {(REQ_DATA_W-1){1'b0}}}, 1'b0);
      add_item(OP_PUSH, 1, {1'b0, {(REQ_DATA_W-1){1'b1}}}, 1'b0);
      add_item(OP_PUSH, 2, '0, 1'b0);
      add_item(OP_PUSH, 3, '1, 1'b0);
      add_item(OP_PUSH, 0, 32'haaaa_aaaa, 1'b0);
      add_item(OP_PUSH, 1, 32'h5555_5555, 1'b0);
      for (int i = 6; i < CAPACITY; i++) begin
         add_item(OP_PUSH, i % QUEUES, REQ_DATA_W'($urandom), 1'b0);
      end
      add_item(OP_PUSH, 2, pick_data(), 1'b0);
      // drain queue 0 past empty, then reuse it with a stale tail
      for (int i = 0; i < 5; i++) begin
         add_item(OP_POP, 0, pick_data(), 1'b0);
      end
      add_item(OP_PUSH, 0, REQ_DATA_W'($urandom), 1'b0);
      add_item(OP_POP, 0, pick_data(), 1'b0);

      // random: phases leaning to push, to pop or to neither, some on one queue, some (always the first) after a drain
      count = 0;
      while (count < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 2);
         len = $urandom_range(8, 40);
         focused = $urandom_range(0, 2) == 0;
         focus_q = $urandom_range(0, QUEUES - 1);
         drain = count == 0 || $urandom_range(0, 7) == 0;
         for (int i = 0; i < len; i++) begin
            case (mode)
               0: op = $urandom_range(0, 9) < 8 ? OP_PUSH : OP_POP;
               1: op = $urandom_range(0, 9) < 8 ? OP_POP : OP_PUSH;
               default: op = $urandom_range(0, 1) == 0 ? OP_PUSH : OP_POP;
            endcase
            add_item(op, focused ? focus_q : $urandom_range(0, (1 << QIDX_W) - 1), pick_data(),
                     drain && i == 0);
         end
         count += len;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // wait for all items to go out and every result to come back
      while (pending_items.size() > 0 || start || expected_rsps.size() > 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_rsps.size()));
      end
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
